// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros included by the tracker core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kstm_pkg.sv =====
// ----------------------------------------------------------------------------
// kstm_pkg
// Types, widths and constants of the key state tracker.
// ----------------------------------------------------------------------------
package kstm_pkg;

    localparam int KEY_CODE_W = 10;
    localparam int MOD_W      = 8;
    localparam int TIME_W     = 32;
    localparam int MASK_W     = 32;

    localparam int CFG_ADDR_W   = 4;
    localparam int CFG_DATA_W   = 6;
    localparam int NUM_CFG_REGS = 8;

    localparam int S_FIELDS_W = KEY_CODE_W + MOD_W + TIME_W;
    localparam int S_TDATA_W  = 56;
    localparam int S_PAD_W    = S_TDATA_W - S_FIELDS_W;

    localparam int M_FIELDS_W = KEY_CODE_W + 1 + TIME_W + 2 * MASK_W + 2;
    localparam int M_TDATA_W  = 112;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SHIFT   = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CAPS    = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CONTROL = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALT     = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MOD2    = 4'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_MOD3    = 4'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_SUPER   = 4'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_MOD5    = 4'd7;

    // result kinds
    localparam logic RESULT_KEY = 1'b0;
    localparam logic RESULT_MOD = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_MOVE   = 6'b001000,
        S_MOD    = 6'b010000,
        S_KEY    = 6'b100000
    } state_t;

    // index 32..63 means the modifier is absent
    function automatic logic [MASK_W-1:0] mod_bit(input logic [CFG_DATA_W-1:0] idx);
        logic [MASK_W-1:0] one;
        one = {{(MASK_W-1){1'b0}}, 1'b1};
        mod_bit = idx[5] ? '0 : (one << idx[4:0]);
    endfunction

endpackage

// ===== rtl/key_state_tracker_modifier_map_core.sv =====
// An accepted item passes through the states SCAN (skipped with an empty table),
// DECIDE, MOVE (matched release only), MOD (changed modifiers only) and KEY;
// a match ends the scan early. The block takes no new item until the last one is
// through; the held-key scan reads one table entry per cycle through the single read port.
// Auto-repeat presses give no result and free the block after the scan.
// Reset (aresetn, synchronous, active low) empties the table, clears the last
// modifiers and loads the default modifier indexes 0..7.
// ----------------------------------------------------------------------------
// key_state_tracker_modifier_map_core
// Tracks held keys in a small table and emits modifier and key results.
// ----------------------------------------------------------------------------
module key_state_tracker_modifier_map_core #(
    parameter int MAX_HELD_KEYS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_we,
    input  logic [kstm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [kstm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [kstm_pkg::S_TDATA_W-1:0]  s_tdata,   // key_code, modifier_vector, event_time
    input  logic                           s_tuser,   // is_press
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [kstm_pkg::M_TDATA_W-1:0]  m_tdata,   // out_key_code, out_pressed, out_time,
                                                       // depressed_mask, locked_mask,
                                                       // release_unmatched, table_full
    output logic                           m_tuser,   // result_kind
    output logic                           m_tlast    // last_of_run
);
    import kstm_pkg::*;

    localparam int IDX_W = (MAX_HELD_KEYS > 1) ? $clog2(MAX_HELD_KEYS) : 1;
    localparam int CNT_W = $clog2(MAX_HELD_KEYS + 1);

    state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] cfg_index_reg [NUM_CFG_REGS];

    logic [KEY_CODE_W-1:0] held_mem [MAX_HELD_KEYS];
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [KEY_CODE_W-1:0] mem_wdata;
    logic [IDX_W-1:0]      rd_addr;
    logic [KEY_CODE_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  rd_vld_reg, rd_vld_next;

    logic [CNT_W-1:0] held_count_reg, held_count_next;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic [MOD_W-1:0] prev_mods_reg, prev_mods_next;

    logic                  is_press_reg;
    logic [KEY_CODE_W-1:0] code_reg;
    logic [MOD_W-1:0]      mods_reg;
    logic [TIME_W-1:0]     time_reg;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      found_idx_reg, found_idx_next;
    logic                  unm_reg, unm_next;
    logic                  full_reg, full_next;

    logic                  out_vld_reg, out_vld_next;
    logic                  out_load_mod, out_load_key;
    logic                  out_kind_reg;
    logic [KEY_CODE_W-1:0] out_code_reg;
    logic                  out_pressed_reg;
    logic [TIME_W-1:0]     out_time_reg;
    logic [MASK_W-1:0]     out_dep_reg;
    logic [MASK_W-1:0]     out_lck_reg;
    logic                  out_unm_reg;
    logic                  out_full_reg;
    logic                  out_last_reg;

    logic                  s_accept;
    logic                  out_free;
    logic                  mods_differ;
    logic                  hit;
    logic                  scan_end;
    logic [MASK_W-1:0]     dep_mask;
    logic [MASK_W-1:0]     lck_mask;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;
    assign mods_differ = (mods_reg != prev_mods_reg);
    assign cnt_m1 = held_count_reg - CNT_W'(1);

    // scan compare unit
    assign hit      = rd_vld_reg && (rd_data_reg == code_reg);
    assign scan_end = rd_vld_reg && (rd_idx_reg == cnt_m1[IDX_W-1:0]);

    assign rd_addr = (state_reg == S_SCAN) ? scan_cnt_reg[IDX_W-1:0] : cnt_m1[IDX_W-1:0];

    always_comb begin
        dep_mask = '0;
        lck_mask = '0;
        if (mods_reg[0]) dep_mask = dep_mask | mod_bit(cfg_index_reg[CFG_SHIFT[2:0]]);
        if (mods_reg[1]) lck_mask = lck_mask | mod_bit(cfg_index_reg[CFG_CAPS[2:0]]);
        if (mods_reg[2]) dep_mask = dep_mask | mod_bit(cfg_index_reg[CFG_CONTROL[2:0]]);
        if (mods_reg[3]) dep_mask = dep_mask | mod_bit(cfg_index_reg[CFG_ALT[2:0]]);
        if (mods_reg[4]) dep_mask = dep_mask | mod_bit(cfg_index_reg[CFG_MOD2[2:0]]);
        if (mods_reg[5]) dep_mask = dep_mask | mod_bit(cfg_index_reg[CFG_MOD3[2:0]]);
        if (mods_reg[6]) dep_mask = dep_mask | mod_bit(cfg_index_reg[CFG_SUPER[2:0]]);
        if (mods_reg[7]) dep_mask = dep_mask | mod_bit(cfg_index_reg[CFG_MOD5[2:0]]);
    end

    always_comb begin
        state_next      = state_reg;
        held_count_next = held_count_reg;
        scan_cnt_next   = scan_cnt_reg;
        prev_mods_next  = prev_mods_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        unm_next        = unm_reg;
        full_next       = full_reg;
        rd_vld_next     = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = held_count_reg[IDX_W-1:0];
        mem_wdata       = code_reg;
        out_load_mod    = 1'b0;
        out_load_key    = 1'b0;
        out_vld_next    = out_vld_reg && !m_tready;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    scan_cnt_next = '0;
                    found_next    = 1'b0;
                    unm_next      = 1'b0;
                    full_next     = 1'b0;
                    state_next    = (held_count_reg == '0) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN: begin
                rd_vld_next   = (scan_cnt_reg < held_count_reg);
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                if (hit) begin
                    found_next     = 1'b1;
                    found_idx_next = rd_idx_reg;
                    state_next     = S_DECIDE;
                end else if (scan_end) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (is_press_reg) begin
                    if (found_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        if (held_count_reg < CNT_W'(MAX_HELD_KEYS)) begin
                            mem_we          = 1'b1;
                            held_count_next = held_count_reg + CNT_W'(1);
                        end else begin
                            full_next = 1'b1;
                        end
                        state_next = mods_differ ? S_MOD : S_KEY;
                    end
                end else begin
                    if (found_reg) begin
                        state_next = S_MOVE;
                    end else begin
                        unm_next   = 1'b1;
                        state_next = mods_differ ? S_MOD : S_KEY;
                    end
                end
            end
            S_MOVE: begin
                mem_we          = 1'b1;
                mem_waddr       = found_idx_reg;
                mem_wdata       = rd_data_reg;
                held_count_next = cnt_m1;
                state_next      = mods_differ ? S_MOD : S_KEY;
            end
            S_MOD: begin
                if (out_free) begin
                    out_load_mod   = 1'b1;
                    out_vld_next   = 1'b1;
                    prev_mods_next = mods_reg;
                    state_next     = S_KEY;
                end
            end
            S_KEY: begin
                if (out_free) begin
                    out_load_key = 1'b1;
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            held_count_reg <= '0;
            scan_cnt_reg   <= '0;
            prev_mods_reg  <= '0;
            found_reg      <= 1'b0;
            unm_reg        <= 1'b0;
            full_reg       <= 1'b0;
            rd_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            for (int i = 0; i < NUM_CFG_REGS; i++) begin
                cfg_index_reg[i] <= CFG_DATA_W'(i);
            end
        end else begin
            state_reg      <= state_next;
            held_count_reg <= held_count_next;
            scan_cnt_reg   <= scan_cnt_next;
            prev_mods_reg  <= prev_mods_next;
            found_reg      <= found_next;
            unm_reg        <= unm_next;
            full_reg       <= full_next;
            rd_vld_reg     <= rd_vld_next;
            out_vld_reg    <= out_vld_next;
            if (cfg_we && (cfg_addr < CFG_ADDR_W'(NUM_CFG_REGS))) begin
                cfg_index_reg[cfg_addr[2:0]] <= cfg_wdata;
            end
        end
    end

    // item capture and scan bookkeeping
    always_ff @(posedge aclk) begin
        found_idx_reg <= found_idx_next;
        if (s_accept) begin
            is_press_reg <= s_tuser;
            code_reg     <= s_tdata[KEY_CODE_W-1:0];
            mods_reg     <= s_tdata[KEY_CODE_W +: MOD_W];
            time_reg     <= s_tdata[KEY_CODE_W+MOD_W +: TIME_W];
        end
    end

    // held-key table
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            held_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= held_mem[rd_addr];
        rd_idx_reg  <= rd_addr;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (out_load_mod) begin
            out_kind_reg    <= RESULT_MOD;
            out_code_reg    <= '0;
            out_pressed_reg <= 1'b0;
            out_time_reg    <= '0;
            out_dep_reg     <= dep_mask;
            out_lck_reg     <= lck_mask;
            out_unm_reg     <= 1'b0;
            out_full_reg    <= 1'b0;
            out_last_reg    <= 1'b0;
        end else if (out_load_key) begin
            out_kind_reg    <= RESULT_KEY;
            out_code_reg    <= code_reg;
            out_pressed_reg <= is_press_reg;
            out_time_reg    <= time_reg;
            out_dep_reg     <= '0;
            out_lck_reg     <= '0;
            out_unm_reg     <= unm_reg;
            out_full_reg    <= full_reg;
            out_last_reg    <= 1'b1;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_full_reg, out_unm_reg, out_lck_reg, out_dep_reg,
                       out_time_reg, out_pressed_reg, out_code_reg};

    `include "assert_macros.svh"

    `ASSERT_IMPL(a_count_max, aclk, aresetn, 1'b1, held_count_reg <= CNT_W'(MAX_HELD_KEYS), "held count above table size")
    `ASSERT_IMPL(a_mod_then_key, aclk, aresetn, out_vld_reg && (out_kind_reg == RESULT_MOD), state_reg == S_KEY, "modifier result without pending key result")
    `ASSERT_NEXT(a_idle_count, aclk, aresetn, state_reg == S_IDLE, held_count_reg == $past(held_count_reg), "held count changed while idle")
    `ASSERT_NEXT(a_accept_scan, aclk, aresetn, s_accept, (state_reg == S_SCAN) || (state_reg == S_DECIDE), "accepted item did not start a scan")

endmodule

// ===== dv/tb_key_state_tracker_modifier_map_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_state_tracker_modifier_map_core
// Self-checking bench for the held-key tracker with modifier mapping.
// Key events go in on the input stream. A local model of the held-key table
// and of the modifier map predicts the modifier and key results of each
// accepted item. The results are compared field by field in arrival order.
// Directed items cover the extremes, auto-repeat, a full table and unmatched
// releases. Several index settings run, among them all-absent and out-of-range
// register writes. Random event streams then run, with random gaps on both
// sides and long output stalls.
// ----------------------------------------------------------------------------
module tb_key_state_tracker_modifier_map_core;
    import kstm_pkg::*;

    localparam int MAX_HELD      = 16;
    localparam int SETTLE_CYCLES = MAX_HELD + 24;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int KEY_POOL_SIZE = 20;
    localparam int MAX_KEY_CODE  = 767;
    localparam int LONG_HOLD     = 400;

    // m_tdata layout, lowest bit first
    localparam int O_PRESSED = KEY_CODE_W;
    localparam int O_TIME    = O_PRESSED + 1;
    localparam int O_DEP     = O_TIME + TIME_W;
    localparam int O_LCK     = O_DEP + MASK_W;
    localparam int O_UNM     = O_LCK + MASK_W;
    localparam int O_FULL    = O_UNM + 1;

    localparam logic [CFG_ADDR_W-1:0] REG_ADDR [NUM_CFG_REGS] = '{
        CFG_SHIFT, CFG_CAPS, CFG_CONTROL, CFG_ALT, CFG_MOD2, CFG_MOD3, CFG_SUPER, CFG_MOD5
    };

    typedef struct packed {
        logic                  kind;
        logic [KEY_CODE_W-1:0] code;
        logic                  pressed;
        logic [TIME_W-1:0]     stamp;
        logic [MASK_W-1:0]     dep;
        logic [MASK_W-1:0]     lck;
        logic                  unmatched;
        logic                  full;
        logic                  last;
    } key_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // model state
    logic [KEY_CODE_W-1:0] held_keys [MAX_HELD];
    int                    held_count = 0;
    logic [MOD_W-1:0]      last_mods = '0;
    logic [CFG_DATA_W-1:0] mod_index [NUM_CFG_REGS];
    key_result_t           result_q [$];
    int                    forwarded_items = 0;
    int                    fail_count = 0;

    // stimulus state
    int                    burst_left = 0;
    bit                    sender_steady = 1'b0;
    logic [MOD_W-1:0]      cur_mods = '0;
    logic [KEY_CODE_W-1:0] key_pool [KEY_POOL_SIZE];

    // receiver state
    int                    rx_hold_req = 0;
    int                    rx_hold_ack = 0;
    int                    rx_hold = 0;
    int                    rx_mode = 0;
    int unsigned           rx_cycle = 0;

    key_state_tracker_modifier_map_core #(
        .MAX_HELD_KEYS(MAX_HELD)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [MASK_W-1:0] index_bit(logic [CFG_DATA_W-1:0] idx);
        return (idx >= MASK_W) ? '0 : (MASK_W'(1) << idx);
    endfunction

    // update the held-key table and queue the results of one accepted item
    function automatic void track_key_event(logic press, logic [KEY_CODE_W-1:0] code,
                                            logic [MOD_W-1:0] mods, logic [TIME_W-1:0] stamp);
        int          slot;
        logic        unmatched;
        logic        full;
        key_result_t r;
        slot = -1;
        unmatched = 1'b0;
        full = 1'b0;
        for (int i = 0; i < held_count; i++) begin
            if (slot < 0 && held_keys[i] == code) slot = i;
        end
        if (press) begin
            if (slot >= 0) return;  // auto-repeat
            if (held_count < MAX_HELD) begin
                held_keys[held_count] = code;
                held_count++;
            end else begin
                full = 1'b1;
            end
        end else if (slot >= 0) begin
            held_keys[slot] = held_keys[held_count - 1];
            held_count--;
        end else begin
            unmatched = 1'b1;
        end
        if (mods != last_mods) begin
            r = '0;
            r.kind = RESULT_MOD;
            for (int j = 0; j < NUM_CFG_REGS; j++) begin
                if (mods[j]) begin
                    if (j == CFG_CAPS) r.lck |= index_bit(mod_index[j]);
                    else r.dep |= index_bit(mod_index[j]);
                end
            end
            last_mods = mods;
            result_q.push_back(r);
        end
        r = '0;
        r.kind = RESULT_KEY;
        r.code = code;
        r.pressed = press;
        r.stamp = stamp;
        r.unmatched = unmatched;
        r.full = full;
        r.last = 1'b1;
        result_q.push_back(r);
        forwarded_items++;
    endfunction

    task automatic compare_field(string name, logic [MASK_W-1:0] exp_v, logic [MASK_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        key_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result, actual kind %0b tdata %0h", $time,
                         m_tuser, m_tdata);
                fail_count++;
            end else begin
                e = result_q.pop_front();
                compare_field("result_kind", e.kind, m_tuser);
                compare_field("out_key_code", e.code, m_tdata[KEY_CODE_W-1:0]);
                compare_field("out_pressed", e.pressed, m_tdata[O_PRESSED]);
                compare_field("out_time", e.stamp, m_tdata[O_TIME +: TIME_W]);
                compare_field("depressed_mask", e.dep, m_tdata[O_DEP +: MASK_W]);
                compare_field("locked_mask", e.lck, m_tdata[O_LCK +: MASK_W]);
                compare_field("release_unmatched", e.unmatched, m_tdata[O_UNM]);
                compare_field("table_full", e.full, m_tdata[O_FULL]);
                compare_field("last_of_run", e.last, m_tlast);
            end
        end
    end

    // result receiver: changing stall patterns plus requested long hold-offs
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_hold_req != rx_hold_ack) begin
            rx_hold_ack <= rx_hold_req;
            rx_hold <= LONG_HOLD;
            m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 99) >= 35);
                2: m_tready <= (rx_cycle[2:0] != 3'b101) && (rx_cycle[2:0] != 3'b110);
                default: m_tready <= ($urandom_range(0, 9) == 0);
            endcase
        end
        if (rx_cycle[7:0] == 8'hFF) rx_mode <= $urandom_range(0, 3);
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_item(logic press, logic [KEY_CODE_W-1:0] code,
                             logic [MOD_W-1:0] mods, logic [TIME_W-1:0] stamp);
        int gap;
        if (burst_left == 0) begin
            gap = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser <= press;
        s_tdata <= {{S_PAD_W{1'b0}}, stamp, mods, code};
        do @(posedge aclk); while (!s_tready);
        track_key_event(press, code, mods, stamp);
        burst_left--;
    endtask

    task automatic stop_stream();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        stop_stream();
        while (result_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (addr < NUM_CFG_REGS) mod_index[addr] = value;
        @(posedge aclk);
    endtask

    // mode 0: all zero, 1: all 31, 2: all 32 (absent), 3: all 63, other: random
    task automatic load_indexes(int mode);
        logic [CFG_DATA_W-1:0] v;
        for (int i = 0; i < NUM_CFG_REGS; i++) begin
            case (mode)
                0: v = '0;
                1: v = 6'd31;
                2: v = 6'd32;
                3: v = '1;
                default: v = ($urandom_range(0, 3) == 0)
                           ? CFG_DATA_W'($urandom_range(32, 63))
                           : CFG_DATA_W'($urandom_range(0, 31));
            endcase
            write_reg(REG_ADDR[i], v);
        end
        // writes to unused indexes must be ignored
        write_reg(CFG_ADDR_W'(NUM_CFG_REGS + $urandom_range(0, 7)),
                  CFG_DATA_W'($urandom_range(0, 63)));
    endtask

    task automatic send_random_item(int mod_change_pct);
        int                    pick;
        logic                  press;
        logic [KEY_CODE_W-1:0] code;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            press = 1'b1;
            code = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        end else if (pick < 80 && held_count != 0) begin
            press = 1'b0;
            code = held_keys[$urandom_range(0, held_count - 1)];
        end else if (pick < 90) begin
            press = 1'b0;
            code = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        end else begin
            press = 1'($urandom_range(0, 1));
            code = KEY_CODE_W'($urandom_range(0, MAX_KEY_CODE));
        end
        if ($urandom_range(0, 99) < mod_change_pct) cur_mods = MOD_W'($urandom_range(0, 255));
        send_item(press, code, cur_mods, $urandom());
    endtask

    task automatic test_directed();
        send_item(1'b1, '0, 8'h00, 32'h0000_0000);
        send_item(1'b1, KEY_CODE_W'(MAX_KEY_CODE), 8'hFF, 32'hFFFF_FFFF);
        send_item(1'b1, KEY_CODE_W'(MAX_KEY_CODE), 8'h00, 32'h1234_5678);    // auto-repeat
        send_item(1'b0, KEY_CODE_W'(MAX_KEY_CODE), 8'hFF, 32'h8000_0001);
        send_item(1'b0, KEY_CODE_W'(MAX_KEY_CODE), 8'hFF, 32'h0000_0002);    // not held
        send_item(1'b0, '0, 8'h00, 32'h5555_5555);
        for (int i = 0; i < MAX_HELD; i++) begin
            send_item(1'b1, KEY_CODE_W'(10'h155 + 37 * i), 8'(1 << (i % MOD_W)), $urandom());
        end
        send_item(1'b1, 10'h2AA, 8'h00, 32'hAAAA_AAAA);         // table full
        send_item(1'b0, KEY_CODE_W'(10'h155 + 37 * 5), 8'h00, 32'h0F0F_0F0F);
        send_item(1'b1, 10'h2AA, 8'h00, 32'hF0F0_F0F0);
        wait_drained();
    endtask

    task automatic test_index_settings();
        for (int mode = 0; mode < 6; mode++) begin
            load_indexes(mode);
            for (int n = 0; n < 40; n++) send_random_item(60);
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        sender_steady = 1'b1;
        rx_hold_req++;
        for (int n = 0; n < 60; n++) send_random_item(30);
        sender_steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_streams(int items_per_phase, int phases);
        int target;
        for (int p = 0; p < phases; p++) begin
            load_indexes(4);
            target = forwarded_items + items_per_phase;
            while (forwarded_items < target) begin
                if (burst_left == 0 && $urandom_range(0, 15) == 0) sender_steady = ~sender_steady;
                send_random_item(25);
            end
            wait_drained();
        end
        sender_steady = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < NUM_CFG_REGS; i++) mod_index[i] = CFG_DATA_W'(i);
        for (int i = 0; i < KEY_POOL_SIZE; i++) begin
            key_pool[i] = KEY_CODE_W'($urandom_range(0, MAX_KEY_CODE));
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_index_settings();
        test_backpressure();
        test_random_streams(150, 8);

        stop_stream();
        while (result_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/kstm_pkg.sv
rtl/key_state_tracker_modifier_map_core.sv
dv/tb_key_state_tracker_modifier_map_core.sv
